@@ rtl/core/lpht_pkg.sv @@
// Shared commands, status codes and flag types of the linear probing hash table.
package lpht_pkg;

  typedef enum logic [1:0] {
    CMD_SET       = 2'd0,
    CMD_SET_EXIST = 2'd1,
    CMD_GET       = 2'd2,
    CMD_DEL       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FLAG_KEEP = 2'd0,
    FLAG_FILL = 2'd1,
    FLAG_KILL = 2'd2
  } flag_op_e;

  typedef struct packed {
    logic used;
    logic tomb;
  } flag_t;

  localparam int unsigned CfgBits  = 9;
  localparam int unsigned CfgReset = 192;

endpackage

@@ rtl/core/lpht_home.sv @@
// Home slot unit: reduces a 32-bit hash modulo the slot count over three steps.
module lpht_home #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [31:0]              hash_i,
  output logic                     done_o,
  output logic [$clog2(SLOTS)-1:0] home_o
);
  import lpht_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam longint unsigned RecipL = 64'h1_0000_0000 / SLOTS;
  localparam logic [31:0] Recip = 32'(RecipL);
  localparam logic [31:0] SlotsW = 32'(SLOTS);

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_MUL  = 4'b0010,
    H_RED  = 4'b0100,
    H_SUB  = 4'b1000
  } hstate_e;

  hstate_e     state_q, state_d;
  logic [31:0] hash_q;
  logic [31:0] prod_q;
  logic [31:0] qs_q;
  logic [31:0] rem;
  logic [31:0] rem_fix;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      H_IDLE:  if (start_i) state_d = H_MUL;
      H_MUL:   state_d = H_RED;
      H_RED:   state_d = H_SUB;
      H_SUB:   state_d = H_IDLE;
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The reciprocal estimate of the quotient is low by at most one, so one
  // conditional subtract finishes the remainder.
  always_ff @(posedge clk_i) begin
    if (start_i && state_q == H_IDLE) begin
      hash_q <= hash_i;
    end
    if (state_q == H_MUL) begin
      prod_q <= 32'((64'(hash_q) * 64'(Recip)) >> 32);
    end
    if (state_q == H_RED) begin
      qs_q <= prod_q * SlotsW;
    end
  end

  assign rem     = hash_q - qs_q;
  assign rem_fix = (rem >= SlotsW) ? (rem - SlotsW) : rem;
  assign home_o  = rem_fix[IW-1:0];
  assign done_o  = (state_q == H_SUB);

endmodule

@@ rtl/core/lpht_store.sv @@
// Slot store: key and value memory with a registered read, plus used and tombstone flags.
module lpht_store #(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(SLOTS)-1:0] rd_addr_i,
  output logic [KEY_BITS-1:0]      rd_key_o,
  output logic [VALUE_BITS-1:0]    rd_val_o,
  output lpht_pkg::flag_t          rd_flag_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(SLOTS)-1:0] wr_addr_i,
  input  logic [KEY_BITS-1:0]      wr_key_i,
  input  logic [VALUE_BITS-1:0]    wr_val_i,
  input  lpht_pkg::flag_op_e       flag_op_i
);
  import lpht_pkg::*;

  logic [KEY_BITS-1:0]   key_mem [SLOTS];
  logic [VALUE_BITS-1:0] val_mem [SLOTS];
  logic [SLOTS-1:0]      used_q;
  logic [SLOTS-1:0]      tomb_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
      val_mem[wr_addr_i] <= wr_val_i;
    end
    if (rd_en_i) begin
      rd_key_o       <= key_mem[rd_addr_i];
      rd_val_o       <= val_mem[rd_addr_i];
      rd_flag_o.used <= used_q[rd_addr_i];
      rd_flag_o.tomb <= tomb_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      tomb_q <= '0;
    end else begin
      unique case (flag_op_i)
        FLAG_FILL: begin
          used_q[wr_addr_i] <= 1'b1;
          tomb_q[wr_addr_i] <= 1'b0;
        end
        FLAG_KILL: begin
          used_q[wr_addr_i] <= 1'b0;
          tomb_q[wr_addr_i] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/linear_probe_hash_table.sv @@
// Top level: open-addressing hash table with linear probing, tombstones and a load limit.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o   command, key_id, key_hash, value
//   out       output     out_valid_o/out_ready_i status, read_value, slot_index
//   cfg       input      cfg_we_i                cfg_wdata_i (max_entries)
//
// A transaction runs the home slot reduction, then checks k slots, where k is 1..SLOTS,
// one slot per cycle through the single registered read port of the slot memory, then
// updates and loads the result, and returns to idle before the next acceptance.
// Get, set existing and delete on an empty table skip the probe.
// Reset clears flags, entry count and control at once; no clearing pass is needed.
// A finished result waits in the output register; a new transaction may be accepted
// meanwhile, and it stalls at its update step until the older result is taken.
module linear_probe_hash_table #(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] key_id_i,
  input  logic [31:0] key_hash_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] read_value_o,
  output logic [7:0]  slot_index_o,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i
);
  import lpht_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned LW = (CW > CfgBits) ? CW : CfgBits;
  localparam logic [CW-1:0] SlotsC = CW'(SLOTS);
  localparam logic [CW-1:0] LastC  = CW'(SLOTS - 1);
  localparam logic [IW-1:0] TopIdx = IW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_HOME   = 4'b0010,
    S_PROBE  = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [CfgBits-1:0]    max_q;
  logic [CW-1:0]         count_q;
  cmd_e                  cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  logic                  accept;
  logic                  home_done;
  logic [IW-1:0]         home;

  logic [IW-1:0]         pos_q;
  logic [CW-1:0]         iss_q;
  logic [CW-1:0]         chk_n_q;
  logic [IW-1:0]         chk_pos_q;
  logic                  rd_vld_q;
  logic                  issue;

  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  flag_t                 rd_flag;

  logic                  found_q;
  logic [IW-1:0]         hit_pos_q;
  logic [VALUE_BITS-1:0] hit_val_q;
  logic                  free_vld_q;
  logic [IW-1:0]         free_pos_q;

  logic                  chk_hit;
  logic                  chk_stop;
  logic                  out_blocked;
  logic                  fin_go;

  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  flag_op_e              flag_op;
  status_e               fin_status;
  logic [VALUE_BITS-1:0] fin_rd;
  logic [IW-1:0]         fin_slot;
  logic                  cnt_inc;
  logic                  cnt_dec;

  logic                  out_valid_q;
  status_e               status_q;
  logic [VALUE_BITS-1:0] rdval_q;
  logic [IW-1:0]         slot_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign issue       = (state_q == S_PROBE) && (iss_q != SlotsC);
  assign out_blocked = out_valid_q && !out_ready_i;
  assign fin_go      = (state_q == S_FINISH) && !out_blocked;

  lpht_home #(
    .SLOTS (SLOTS)
  ) u_home (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .hash_i  (key_hash_i),
    .done_o  (home_done),
    .home_o  (home)
  );

  lpht_store #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (issue),
    .rd_addr_i (pos_q),
    .rd_key_o  (rd_key),
    .rd_val_o  (rd_val),
    .rd_flag_o (rd_flag),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_key_i  (key_q),
    .wr_val_i  (val_q),
    .flag_op_i (flag_op)
  );

  // A checked slot ends the probe on a key match, on a never-used slot, or as the
  // last slot of the lap. Reads issued past that point are dropped.
  assign chk_hit  = rd_vld_q && rd_flag.used && (rd_key == key_q);
  assign chk_stop = rd_vld_q && (chk_hit || (!rd_flag.used && !rd_flag.tomb) ||
                                 (chk_n_q == LastC));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = S_HOME;
      S_HOME: begin
        if (home_done) begin
          if (cmd_q != CMD_SET && count_q == '0) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_PROBE;
          end
        end
      end
      S_PROBE:  if (chk_stop) state_d = S_FINISH;
      S_FINISH: if (!out_blocked) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = hit_pos_q;
    flag_op    = FLAG_KEEP;
    fin_status = ST_MISS;
    fin_rd     = '0;
    fin_slot   = '0;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    if (found_q) begin
      fin_status = ST_OK;
      fin_slot   = hit_pos_q;
      unique case (cmd_q)
        CMD_SET, CMD_SET_EXIST: wr_en = fin_go;
        CMD_GET:                fin_rd = hit_val_q;
        CMD_DEL: begin
          flag_op = fin_go ? FLAG_KILL : FLAG_KEEP;
          cnt_dec = fin_go;
        end
        default: ;
      endcase
    end else if (cmd_q == CMD_SET) begin
      if ((LW'(count_q) >= LW'(max_q)) || !free_vld_q) begin
        fin_status = ST_FULL;
      end else begin
        fin_status = ST_OK;
        fin_slot   = free_pos_q;
        wr_addr    = free_pos_q;
        wr_en      = fin_go;
        flag_op    = fin_go ? FLAG_FILL : FLAG_KEEP;
        cnt_inc    = fin_go;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_q       <= CfgBits'(CfgReset);
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (cnt_inc) begin
        count_q <= count_q + 1'b1;
      end else if (cnt_dec) begin
        count_q <= count_q - 1'b1;
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(command_i);
      key_q <= KEY_BITS'(key_id_i);
      val_q <= VALUE_BITS'(value_i);
    end
    if (state_q == S_HOME && home_done) begin
      pos_q      <= home;
      iss_q      <= '0;
      chk_n_q    <= '0;
      found_q    <= 1'b0;
      free_vld_q <= 1'b0;
    end
    if (issue) begin
      chk_pos_q <= pos_q;
      iss_q     <= iss_q + 1'b1;
      pos_q     <= (pos_q == TopIdx) ? '0 : pos_q + 1'b1;
    end
    if (state_q == S_PROBE && rd_vld_q) begin
      chk_n_q <= chk_n_q + 1'b1;
      // The first slot without a live key on the path is where a new key goes.
      if (!rd_flag.used && !free_vld_q) begin
        free_vld_q <= 1'b1;
        free_pos_q <= chk_pos_q;
      end
      if (chk_hit) begin
        found_q   <= 1'b1;
        hit_pos_q <= chk_pos_q;
        hit_val_q <= rd_val;
      end
    end
    if (fin_go) begin
      status_q <= fin_status;
      rdval_q  <= fin_rd;
      slot_q   <= fin_slot;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_value_o = 64'(rdval_q);
  assign slot_index_o = 8'(slot_q);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SlotsC)
    else $error("entry count exceeds the slot count");

  a_count_changes_on_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(state_q == S_FINISH))
    else $error("entry count changed outside the update step");

  a_miss_payload_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (read_value_o == '0 && slot_index_o == '0))
    else $error("failed transaction carries a slot or value");

  a_result_after_probe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result loaded outside the update step");

endmodule
